// File: hdl/row_record_deserializer_macros.svh
// assertion macros shared by the row record deserializer
`ifndef ROW_RECORD_DESERIALIZER_MACROS_SVH
`define ROW_RECORD_DESERIALIZER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define RRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrd assertion failed");
// next-cycle implication, sampled on clk, off during rst
`define RRD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrd assertion failed");
`else
`define RRD_ASSERT_IMP(label, ante, cons)
`define RRD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hdl/rrd_pkg.sv
`timescale 1ns / 1ps
package rrd_pkg;

  localparam int MAX_COLUMNS = 8;
  localparam int KIND_SLOTS  = 8;
  localparam int COL_LIMIT_I = (MAX_COLUMNS < KIND_SLOTS) ? MAX_COLUMNS : KIND_SLOTS;
  localparam logic [3:0] COL_LIMIT = 4'(COL_LIMIT_I);

  localparam logic [2:0] FIXED_LAST = 3'd7;

  // configuration register indexes
  localparam logic [0:0] CFG_COLUMN_KINDS = 1'b0;
  localparam logic [0:0] CFG_COLUMN_COUNT = 1'b1;

  // column kind codes in column_kinds
  localparam logic [1:0] COL_STRING = 2'd3;

  typedef enum logic [2:0] {
    PH_EXPIRY   = 3'd0,
    PH_INT      = 3'd1,
    PH_DECIMAL  = 3'd2,
    PH_DATETIME = 3'd3,
    PH_STRLEN   = 3'd4,
    PH_STRBYTE  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_EXPIRY   = 3'd0,
    KIND_INT      = 3'd1,
    KIND_DECIMAL  = 3'd2,
    KIND_DATETIME = 3'd3,
    KIND_STRLEN   = 3'd4,
    KIND_STRBYTE  = 3'd5,
    KIND_ERROR    = 3'd6
  } item_kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    item_kind_t  item_kind;
    logic [2:0]  column_index;
    logic [63:0] value_bits;
    logic        row_done;
  } out_item_t;

  // handoff from the input register to the parse stage
  typedef struct packed {
    logic     valid;
    in_item_t data;
  } stage_t;

endpackage

// File: hdl/rrd_in_reg.sv
`timescale 1ns / 1ps
module rrd_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rrd_pkg::in_item_t in_data,
  input  logic             take,
  output rrd_pkg::stage_t  stage
);
  import rrd_pkg::*;

  logic     held;
  in_item_t held_data;

  assign in_ready   = !held || take;
  assign stage.valid = held;
  assign stage.data  = held_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

// File: hdl/rrd_parser.sv
`timescale 1ns / 1ps
module rrd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  rrd_pkg::in_item_t  in_data,
  input  logic [15:0]        column_kinds,
  input  logic [3:0]         column_count,
  output logic               emit,
  output rrd_pkg::out_item_t result
);
  import rrd_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  cur_col, cur_col_next;
  logic [2:0]  pos, pos_next;
  logic [63:0] acc, acc_next;
  logic [15:0] remaining, remaining_next;
  logic        skipping, skipping_next;

  logic [3:0]  eff_count;
  logic [63:0] acc_fixed;
  logic [15:0] len_merged;
  logic [15:0] rem_dec;
  logic        enter;
  logic [3:0]  enter_col;
  logic [1:0]  enter_kind;
  logic        complete;
  logic        val_emit;
  item_kind_t  kind_out;
  logic [2:0]  col_out;
  logic [63:0] val_out;

  assign eff_count  = (column_count > COL_LIMIT) ? COL_LIMIT : column_count;
  assign acc_fixed  = acc | ({56'd0, in_data.byte_value} << {pos, 3'b000});
  assign len_merged = acc[15:0] | ({8'd0, in_data.byte_value} << {pos[0], 3'b000});
  assign rem_dec    = (remaining != 16'd0) ? remaining - 16'd1 : 16'd0;
  assign enter_kind = column_kinds[{enter_col[2:0], 1'b0} +: 2];

  always_comb begin
    phase_next     = phase;
    cur_col_next   = cur_col;
    pos_next       = pos;
    acc_next       = acc;
    remaining_next = remaining;
    skipping_next  = skipping;
    enter          = 1'b0;
    enter_col      = cur_col + 4'd1;
    complete       = 1'b0;
    val_emit       = 1'b0;
    kind_out       = KIND_EXPIRY;
    col_out        = cur_col[2:0];
    val_out        = 64'd0;
    emit           = 1'b0;
    result         = '0;

    if (skipping) begin
      // tail after a complete row: drop bytes until the buffer ends
      if (in_data.last_byte) begin
        phase_next     = PH_EXPIRY;
        cur_col_next   = 4'd0;
        pos_next       = 3'd0;
        acc_next       = 64'd0;
        remaining_next = 16'd0;
        skipping_next  = 1'b0;
      end
    end else begin
      case (phase)
        PH_EXPIRY, PH_INT, PH_DECIMAL, PH_DATETIME: begin
          if (pos == FIXED_LAST) begin
            val_emit  = 1'b1;
            kind_out  = item_kind_t'(phase);
            val_out   = acc_fixed;
            enter     = 1'b1;
            enter_col = (phase == PH_EXPIRY) ? 4'd0 : cur_col + 4'd1;
          end else begin
            pos_next = pos + 3'd1;
            acc_next = acc_fixed;
          end
        end
        PH_STRLEN: begin
          if (pos != 3'd0) begin
            val_emit = 1'b1;
            kind_out = KIND_STRLEN;
            val_out  = {48'd0, len_merged};
            if (len_merged == 16'd0) begin
              enter = 1'b1;
            end else begin
              phase_next     = PH_STRBYTE;
              remaining_next = len_merged;
              pos_next       = 3'd0;
              acc_next       = 64'd0;
            end
          end else begin
            pos_next = pos + 3'd1;
            acc_next = {48'd0, len_merged};
          end
        end
        PH_STRBYTE: begin
          val_emit       = 1'b1;
          kind_out       = KIND_STRBYTE;
          val_out        = {56'd0, in_data.byte_value};
          remaining_next = rem_dec;
          if (rem_dec == 16'd0) begin
            enter = 1'b1;
          end
        end
        default: begin
          // stray phase code: restart with this byte as expiry byte zero
          phase_next     = PH_EXPIRY;
          cur_col_next   = 4'd0;
          pos_next       = 3'd1;
          acc_next       = {56'd0, in_data.byte_value};
          remaining_next = 16'd0;
          col_out        = 3'd0;
        end
      endcase

      if (enter) begin
        cur_col_next   = enter_col;
        pos_next       = 3'd0;
        acc_next       = 64'd0;
        remaining_next = 16'd0;
        if (enter_col >= eff_count) begin
          complete = 1'b1;
        end else if (enter_kind == COL_STRING) begin
          phase_next = PH_STRLEN;
        end else begin
          phase_next = phase_t'({1'b0, enter_kind} + 3'd1);
        end
      end

      if (in_data.last_byte && !complete) begin
        // buffer ended early: error replaces any value from this byte
        emit                = 1'b1;
        result.item_kind    = KIND_ERROR;
        result.column_index = col_out;
        result.value_bits   = 64'd0;
        result.row_done     = 1'b1;
      end else begin
        emit                = val_emit;
        result.item_kind    = kind_out;
        result.column_index = col_out;
        result.value_bits   = val_out;
        result.row_done     = complete;
      end

      if (in_data.last_byte) begin
        phase_next     = PH_EXPIRY;
        cur_col_next   = 4'd0;
        pos_next       = 3'd0;
        acc_next       = 64'd0;
        remaining_next = 16'd0;
        skipping_next  = 1'b0;
      end else if (complete) begin
        skipping_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_EXPIRY;
      cur_col   <= 4'd0;
      pos       <= 3'd0;
      acc       <= 64'd0;
      remaining <= 16'd0;
      skipping  <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      cur_col   <= cur_col_next;
      pos       <= pos_next;
      acc       <= acc_next;
      remaining <= remaining_next;
      skipping  <= skipping_next;
    end
  end

endmodule

// File: hdl/row_record_deserializer.sv
`timescale 1ns / 1ps
`include "row_record_deserializer_macros.svh"
// Row record parser, one record byte per word. A record is an 8-byte
// little-endian expiry stamp followed by one field per configured column;
// int, decimal and datetime columns are 8 little-endian bytes, a string
// column is a 2-byte little-endian length and then that many bytes. Every
// finished value, string length and string byte comes out as one result
// word with its column index; row_done marks the word that ends the row.
// If last_byte arrives before the row is complete the only result for that
// byte is a truncation error. Bytes after a complete row produce nothing
// until last_byte. Throughput is one byte per clock while out_ready does
// not stall the output. An accepted byte sits in the input register, and
// the single parse step moves its result into the result register when the
// result register is free. A result waiting on out_ready holds the next
// byte in the input register, and input stalls only while
// both registers are full. Configuration writes (cfg_index 0 column_kinds,
// 1 column_count, counts above 8 act as 8) take effect at once and belong
// in idle periods between records.
module row_record_deserializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import rrd_pkg::*;

  // configuration registers
  logic [15:0] column_kinds;
  logic [3:0]  column_count;

  stage_t    stage;
  logic      out_free;
  logic      take;
  logic      emit;
  out_item_t result;

  // result register can take a word when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign take     = stage.valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_kinds <= 16'd0;
      column_count <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMN_KINDS: column_kinds <= cfg_wdata;
        CFG_COLUMN_COUNT: column_count <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  rrd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .stage    (stage)
  );

  rrd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (take),
    .in_data      (stage.data),
    .column_kinds (column_kinds),
    .column_count (column_count),
    .emit         (emit),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data <= result;
    end
  end

  // a parsed word never lands on a result still waiting
  `RRD_ASSERT_IMP(a_no_overwrite, take && emit, out_free)
  // a truncation error always closes the row with zero value
  `RRD_ASSERT_IMP(a_error_shape, out_valid && out_data.item_kind == KIND_ERROR,
                  out_data.row_done && out_data.value_bits == 64'd0)
  // expiry stamps belong to column zero
  `RRD_ASSERT_IMP(a_expiry_col, out_valid && out_data.item_kind == KIND_EXPIRY,
                  out_data.column_index == 3'd0)
  // string bytes and lengths keep their upper 48 value bits zero
  `RRD_ASSERT_IMP(a_str_width, out_valid && (out_data.item_kind == KIND_STRBYTE ||
                  out_data.item_kind == KIND_STRLEN), out_data.value_bits[63:16] == 48'd0)
  // an emitted word is registered on the next edge
  `RRD_ASSERT_NXT(a_emit_lands, take && emit, out_valid)

endmodule
